[hdl/keyframe_vec3_lerp_sampler_assert.svh]
`ifndef KEYFRAME_VEC3_LERP_SAMPLER_ASSERT_SVH
`define KEYFRAME_VEC3_LERP_SAMPLER_ASSERT_SVH
`ifndef SYNTH
`define KVLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define KVLS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KVLS_ASSERT(lbl, prop, msg)
`define KVLS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

[hdl/kvls_pkg.sv]
package kvls_pkg;

  localparam int MAX_KEYS_DEF = 64;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_PTR_W   = 2;
  localparam int FIFO_CNT_W   = 3;
  localparam int FRAC_W       = 17;
  localparam int DIV_CNT_W    = 5;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic              op;
    logic [5:0]        key_index;
    logic [31:0]       time_val;
    logic [2:0][31:0]  v;
  } cmd_t;

  typedef struct packed {
    logic [31:0]       time_val;
    logic [2:0][31:0]  v;
  } kv_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

[hdl/keyframe_vec3_lerp_sampler.sv]
// Channel   Handshake             Word
// ------    --------------------  ---------------------------------------------
// in        in_valid / in_ready   func, key_index, key_time, key_x/y/z, sample_time
// out       out_valid / out_ready out_x, out_y, out_z, segment
// cfg       cfg_we                key_count
//
// Keyframe write: stored in the back end in the same cycle it leaves the queue.
// Query: passes the key table scan (one read per cycle), the 17-bit fraction
// divider and one shared multiplier.
// Reset clears queue, state and key_count (to 1); the table is not cleared.
// The front register and 4-word queue keep taking words while a query runs
// or a result waits on out_ready.
`include "keyframe_vec3_lerp_sampler_assert.svh"

module keyframe_vec3_lerp_sampler #(
  parameter int MAX_KEYS = kvls_pkg::MAX_KEYS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [6:0]          key_count,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                func,
  input  logic [5:0]          key_index,
  input  logic [31:0]         key_time,
  input  logic signed [31:0]  key_x,
  input  logic signed [31:0]  key_y,
  input  logic signed [31:0]  key_z,
  input  logic [31:0]         sample_time,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  output logic [5:0]          segment
);

  logic                 fifo_push;
  logic                 fifo_pop;
  kvls_pkg::cmd_t       push_data;
  kvls_pkg::cmd_t       pop_data;
  kvls_pkg::fifo_stat_t fifo_stat;

  kvls_front #(.MAX_KEYS(MAX_KEYS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .key_index   (key_index),
    .key_time    (key_time),
    .key_x       (key_x),
    .key_y       (key_y),
    .key_z       (key_z),
    .sample_time (sample_time),
    .stat        (fifo_stat),
    .push        (fifo_push),
    .push_data   (push_data)
  );

  kvls_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fifo_push),
    .push_data (push_data),
    .pop       (fifo_pop),
    .pop_data  (pop_data),
    .stat      (fifo_stat)
  );

  kvls_core #(.MAX_KEYS(MAX_KEYS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .key_count (key_count),
    .pop_data  (pop_data),
    .stat      (fifo_stat),
    .pop       (fifo_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .segment   (segment)
  );

  `KVLS_ASSERT(a_no_overflow, !(fifo_push && fifo_stat.full), "push into full queue")
  `KVLS_ASSERT(a_no_underflow, !(fifo_pop && fifo_stat.empty), "pop from empty queue")
  `KVLS_ASSERT(a_seg_range, out_valid |-> (32'(segment) < MAX_KEYS), "segment past table")
  `KVLS_ASSERT_RST(a_reset, rst |=> (!out_valid && in_ready), "bad state after reset")

endmodule

[hdl/kvls_fifo.sv]
module kvls_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  kvls_pkg::cmd_t      push_data,
  input  logic                pop,
  output kvls_pkg::cmd_t      pop_data,
  output kvls_pkg::fifo_stat_t stat
);

  kvls_pkg::cmd_t                       q [kvls_pkg::FIFO_DEPTH];
  logic [kvls_pkg::FIFO_PTR_W-1:0]      wptr;
  logic [kvls_pkg::FIFO_PTR_W-1:0]      rptr;
  logic [kvls_pkg::FIFO_CNT_W-1:0]      count;

  assign pop_data   = q[rptr];
  assign stat.full  = (count == kvls_pkg::FIFO_CNT_W'(kvls_pkg::FIFO_DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= push_data;
    end
  end

endmodule

[hdl/kvls_front.sv]
module kvls_front #(
  parameter int MAX_KEYS = kvls_pkg::MAX_KEYS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 func,
  input  logic [5:0]           key_index,
  input  logic [31:0]          key_time,
  input  logic signed [31:0]   key_x,
  input  logic signed [31:0]   key_y,
  input  logic signed [31:0]   key_z,
  input  logic [31:0]          sample_time,
  input  kvls_pkg::fifo_stat_t stat,
  output logic                 push,
  output kvls_pkg::cmd_t       push_data
);

  logic           fr_valid;
  kvls_pkg::cmd_t fr_data;
  kvls_pkg::cmd_t cls;
  logic           keep;

  // writes past the table are dropped here
  always_comb begin
    cls.op        = func;
    cls.key_index = key_index;
    cls.time_val  = (func == kvls_pkg::OP_QUERY) ? sample_time : key_time;
    cls.v         = {key_z, key_y, key_x};
    keep          = (func == kvls_pkg::OP_QUERY) || (32'(key_index) < MAX_KEYS);
  end

  assign push      = fr_valid && !stat.full;
  assign in_ready  = !fr_valid || !stat.full;
  assign push_data = fr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      fr_valid <= keep;
    end else if (push) begin
      fr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fr_data <= cls;
    end
  end

endmodule

[hdl/kvls_core.sv]
module kvls_core #(
  parameter int MAX_KEYS = kvls_pkg::MAX_KEYS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [6:0]           key_count,
  input  kvls_pkg::cmd_t       pop_data,
  input  kvls_pkg::fifo_stat_t stat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_x,
  output logic signed [31:0]   out_y,
  output logic signed [31:0]   out_z,
  output logic [5:0]           segment
);

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_ACC   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  kvls_pkg::kv_t mem [MAX_KEYS];
  kvls_pkg::kv_t rd;
  kvls_pkg::kv_t wd;
  kvls_pkg::kv_t lo;
  kvls_pkg::kv_t hi;
  logic          mem_we;
  logic [AW-1:0] wa;
  logic [AW-1:0] ra;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [6:0]    kc;
  logic [AW-1:0] last;
  logic [AW-1:0] idx;
  logic [AW-1:0] sidx;
  logic [31:0]   tq;
  logic          hit;
  logic          load;

  logic [32:0]                         rem;
  logic [32:0]                         trial;
  logic [31:0]                         dvs;
  logic [kvls_pkg::FRAC_W-1:0]         q;
  logic [kvls_pkg::DIV_CNT_W-1:0]      cnt;
  logic [1:0]                          comp;
  logic signed [32:0]                  dlt;
  logic signed [kvls_pkg::FRAC_W:0]    fs;
  logic signed [50:0]                  prod;
  logic signed [50:0]                  sum;
  logic [2:0][31:0]                    res;

  // last key in use, count clamped to 1..MAX_KEYS
  always_comb begin
    if (kc == '0) begin
      last = '0;
    end else if (32'(kc) > MAX_KEYS) begin
      last = AW'(MAX_KEYS - 1);
    end else begin
      last = AW'(32'(kc) - 32'd1);
    end
  end

  assign hit   = (lo.time_val <= tq) && (tq <= rd.time_val);
  assign load  = !out_valid || out_ready;
  assign wa    = AW'(pop_data.key_index);
  assign trial = (cnt == '0) ? rem : {rem[31:0], 1'b0};
  assign dlt   = 33'($signed(hi.v[comp])) - 33'($signed(lo.v[comp]));
  assign fs    = $signed({1'b0, q});
  assign sum   = 51'($signed(lo.v[comp])) + (prod >>> 16);

  always_comb begin
    wd.time_val = pop_data.time_val;
    wd.v        = pop_data.v;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    mem_we     = 1'b0;
    ra         = idx;
    case (state)
      S_IDLE: begin
        if (!stat.empty) begin
          pop = 1'b1;
          if (pop_data.op == kvls_pkg::OP_WRITE) begin
            mem_we = 1'b1;
          end else begin
            ra         = '0;
            state_next = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        if (last == '0 || tq <= rd.time_val) begin
          state_next = S_OUT;
        end else begin
          ra         = AW'(1);
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_next = (rd.time_val == lo.time_val) ? S_OUT : S_DIV;
        end else if (idx == last) begin
          state_next = S_OUT;
        end else begin
          ra = idx + 1'b1;
        end
      end
      S_DIV: begin
        if (cnt == kvls_pkg::DIV_CNT_W'(kvls_pkg::FRAC_W - 1)) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_ACC;
      end
      S_ACC: begin
        state_next = (comp == 2'd2) ? S_OUT : S_MUL;
      end
      S_OUT: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      kc        <= 7'd1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        kc <= key_count;
      end
      if (state == S_OUT && load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        tq <= pop_data.time_val;
      end
      S_FIRST: begin
        res  <= rd.v;
        sidx <= '0;
        lo   <= rd;
        idx  <= AW'(1);
      end
      S_SCAN: begin
        if (hit) begin
          sidx <= idx - 1'b1;
          res  <= lo.v;
          hi   <= rd;
          rem  <= {1'b0, tq - lo.time_val};
          dvs  <= rd.time_val - lo.time_val;
          cnt  <= '0;
        end else if (idx == last) begin
          res  <= rd.v;
          sidx <= idx;
        end else begin
          lo  <= rd;
          idx <= idx + 1'b1;
        end
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle
        if (trial >= {1'b0, dvs}) begin
          rem <= trial - {1'b0, dvs};
          q   <= {q[kvls_pkg::FRAC_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[kvls_pkg::FRAC_W-2:0], 1'b0};
        end
        cnt  <= cnt + 1'b1;
        comp <= '0;
      end
      S_MUL: begin
        prod <= dlt * fs;
      end
      S_ACC: begin
        res[comp] <= sum[31:0];
        comp      <= comp + 1'b1;
      end
      S_OUT: begin
        if (load) begin
          out_x   <= res[0];
          out_y   <= res[1];
          out_z   <= res[2];
          segment <= 6'(sidx);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[dv/keyframe_vec3_lerp_sampler_tb.sv]
module keyframe_vec3_lerp_sampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_SLOTS    = kvls_pkg::MAX_KEYS_DEF;
  localparam int TOTAL_WORDS  = 820;
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_CYCLES  = 600;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [5:0]  seg;
  } sample_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_WRITE, ROW_QUERY} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [6:0]  kc;
    logic [5:0]  idx;
    logic [31:0] tm;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        typed;
    sample_t     want;
  } dir_row_t;

  // tm is the key time for writes and the sample time for queries
  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_WRITE, 7'd0, 6'd0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0, '0},
    '{ROW_QUERY, 7'd0, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1,
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 6'd0}},
    '{ROW_QUERY, 7'd0, 6'd0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b1,
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 6'd0}},
    '{ROW_WRITE, 7'd0, 6'd1, 32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000,
      1'b0, '0},
    '{ROW_WRITE, 7'd0, 6'd2, 32'h0003_0000, 32'h1, 32'h2, 32'h3, 1'b0, '0},
    '{ROW_WRITE, 7'd0, 6'd3, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, '0},
    '{ROW_WRITE, 7'd0, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_CFG, 7'd0, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_QUERY, 7'd0, 6'd0, 32'h0002_0000, 32'h0, 32'h0, 32'h0, 1'b1,
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 6'd0}},
    '{ROW_CFG, 7'd4, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_QUERY, 7'd0, 6'd0, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 1'b1,
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 6'd0}},
    '{ROW_QUERY, 7'd0, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1,
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 6'd0}},
    '{ROW_QUERY, 7'd0, 6'd0, 32'h0002_0000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_QUERY, 7'd0, 6'd0, 32'h0003_0000, 32'h0, 32'h0, 32'h0, 1'b1,
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 6'd0}},
    '{ROW_QUERY, 7'd0, 6'd0, 32'h0002_8000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_QUERY, 7'd0, 6'd0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_QUERY, 7'd0, 6'd0, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_CFG, 7'd3, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_QUERY, 7'd0, 6'd0, 32'h0005_0000, 32'h0, 32'h0, 32'h0, 1'b1,
      '{32'h1, 32'h2, 32'h3, 6'd2}},
    '{ROW_QUERY, 7'd0, 6'd0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b1,
      '{32'h1, 32'h2, 32'h3, 6'd2}},
    '{ROW_CFG, 7'd2, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_QUERY, 7'd0, 6'd0, 32'h0001_8000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_CFG, 7'd1, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_QUERY, 7'd0, 6'd0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b1,
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 6'd0}}
  };

  localparam logic [6:0] FORCED_KC [6] = '{7'd1, 7'd0, 7'd64, 7'd127, 7'd65, 7'd2};

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               cfg_we      = 1'b0;
  logic [6:0]         key_count   = 7'd1;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic               func        = kvls_pkg::OP_WRITE;
  logic [5:0]         key_index   = 6'd0;
  logic [31:0]        key_time    = 32'h0;
  logic signed [31:0] key_x       = 32'sh0;
  logic signed [31:0] key_y       = 32'sh0;
  logic signed [31:0] key_z       = 32'sh0;
  logic [31:0]        sample_time = 32'h0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic [5:0]         segment;

  // shadow of the key table and the key count register
  logic [31:0] key_tm [KEY_SLOTS];
  logic [31:0] key_xs [KEY_SLOTS];
  logic [31:0] key_ys [KEY_SLOTS];
  logic [31:0] key_zs [KEY_SLOTS];
  logic [6:0]  cfg_keys = 7'd1;

  sample_t pending_samples [$];
  int      mismatch_count = 0;
  int      words_sent     = 0;
  int      burst_left     = 1;
  bit      hold_off_req   = 1'b0;

  keyframe_vec3_lerp_sampler dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .key_count   (key_count),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .key_index   (key_index),
    .key_time    (key_time),
    .key_x       (key_x),
    .key_y       (key_y),
    .key_z       (key_z),
    .sample_time (sample_time),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .segment     (segment)
  );

  always #6 clk = ~clk;

  function automatic logic [31:0] lerp_q16(input logic signed [31:0] a,
                                           input logic signed [31:0] b,
                                           input logic [16:0] f);
    longint d;
    longint p;
    d = longint'(b) - longint'(a);
    p = d * longint'(f);
    return 32'(longint'(a) + (p >>> 16));
  endfunction

  function automatic sample_t sample_keys(input logic [31:0] st);
    sample_t     r;
    int          n;
    logic [31:0] t0;
    logic [31:0] t1;
    logic [31:0] dt;
    logic [47:0] num;
    logic [16:0] f;
    bit          hit;
    n = (cfg_keys == 7'd0) ? 1 : ((cfg_keys > KEY_SLOTS) ? KEY_SLOTS : int'(cfg_keys));
    hit = 1'b0;
    r = '{key_xs[0], key_ys[0], key_zs[0], 6'd0};
    if (n == 1 || st <= key_tm[0]) return r;
    for (int i = 0; i + 1 < n && !hit; i++) begin
      t0 = key_tm[i];
      t1 = key_tm[i + 1];
      if (t0 <= st && st <= t1) begin
        hit = 1'b1;
        dt = t1 - t0;
        if (dt == 32'h0) begin
          r = '{key_xs[i], key_ys[i], key_zs[i], 6'(i)};
        end else begin
          num = {st - t0, 16'h0000};
          f = 17'(num / {16'h0000, dt});
          r = '{lerp_q16(key_xs[i], key_xs[i + 1], f), lerp_q16(key_ys[i], key_ys[i + 1], f),
                lerp_q16(key_zs[i], key_zs[i + 1], f), 6'(i)};
        end
      end
    end
    if (!hit) r = '{key_xs[n - 1], key_ys[n - 1], key_zs[n - 1], 6'(n - 1)};
    return r;
  endfunction

  function automatic logic [31:0] pick_sample_time(input int n);
    int          j;
    logic [31:0] lo;
    logic [31:0] hi;
    j = $urandom_range(0, n - 1);
    lo = key_tm[j];
    hi = (j + 1 < n) ? key_tm[j + 1] : 32'hFFFF_FFFF;
    case ($urandom_range(0, 7))
      0: return lo;
      1: return hi;
      2: return lo - 32'h1;
      3: return 32'h0;
      4: return 32'hFFFF_FFFF;
      5: return $urandom;
      default: return (hi > lo) ? lo + $urandom_range(0, hi - lo) : lo;
    endcase
  endfunction

  function automatic logic [31:0] key_value(input bit narrow);
    return narrow ? $urandom_range(0, 32'h0020_0000) - 32'h0010_0000 : $urandom;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("%0t: mismatch: %s", $realtime, msg);
  endtask

  // drive one word and hold it until accepted; on acceptance update the shadow or queue the expected result
  task automatic push_word(input logic f, input logic [5:0] idx, input logic [31:0] kt,
                           input logic [31:0] kx, ky, kz, st,
                           input bit has_want, input sample_t want);
    sample_t exp_word;
    func        <= f;
    key_index   <= idx;
    key_time    <= kt;
    key_x       <= kx;
    key_y       <= ky;
    key_z       <= kz;
    sample_time <= st;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    words_sent++;
    if (f == kvls_pkg::OP_WRITE) begin
      key_tm[idx] = kt;
      key_xs[idx] = kx;
      key_ys[idx] = ky;
      key_zs[idx] = kz;
    end else begin
      exp_word = has_want ? want : sample_keys(st);
      pending_samples = {pending_samples, exp_word};
    end
  endtask

  task automatic idle_gap(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic pace();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_samples.size() != 0);
  endtask

  task automatic set_key_count(input logic [6:0] v);
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    key_count <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_keys = v;
  endtask

  always @(posedge clk) begin : result_check
    sample_t e;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_samples.size() == 0) begin
        flag_mismatch($sformatf("result word with none expected: %h %h %h seg %0d",
                                out_x, out_y, out_z, segment));
      end else begin
        e = pending_samples.pop_front();
        if (out_x !== e.x) flag_mismatch($sformatf("out_x %h, want %h", out_x, e.x));
        if (out_y !== e.y) flag_mismatch($sformatf("out_y %h, want %h", out_y, e.y));
        if (out_z !== e.z) flag_mismatch($sformatf("out_z %h, want %h", out_z, e.z));
        if (segment !== e.seg)
          flag_mismatch($sformatf("segment %0d, want %0d", segment, e.seg));
      end
    end
  end

  // receiver: stall pattern picks a new random mode periodically; long hold-off on request
  initial begin : rx_pace
    int rx_mode;
    int rx_cnt;
    rx_mode = 0;
    rx_cnt  = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        out_ready <= 1'b1;
      end else begin
        rx_cnt++;
        if (rx_cnt % 64 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= (rx_cnt % 5 < 2);
        endcase
      end
    end
  end

  initial begin : stim
    int          phase;
    int          n;
    int          style;
    int          sel;
    bit          narrow;
    logic [6:0]  kc;
    logic [31:0] t_cur;
    logic [31:0] span;
    dir_row_t    row;

    for (int i = 0; i < KEY_SLOTS; i++) begin
      key_tm[i] = 32'h0;
      key_xs[i] = 32'h0;
      key_ys[i] = 32'h0;
      key_zs[i] = 32'h0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIRECTED[r];
      case (row.kind)
        ROW_CFG:   set_key_count(row.kc);
        ROW_WRITE: push_word(kvls_pkg::OP_WRITE, row.idx, row.tm, row.x, row.y, row.z,
                             $urandom, 1'b0, '0);
        default:   push_word(kvls_pkg::OP_QUERY, 6'($urandom), $urandom, $urandom,
                             $urandom, $urandom, row.tm, row.typed, row.want);
      endcase
      pace();
    end

    phase = 0;
    while (words_sent < TOTAL_WORDS) begin
      if (phase < 6) begin
        kc = FORCED_KC[phase];
      end else begin
        sel = $urandom_range(0, 9);
        if (sel < 6) kc = 7'($urandom_range(2, 8));
        else if (sel < 8) kc = 7'($urandom_range(0, 127));
        else kc = 7'($urandom_range(9, 20));
      end
      set_key_count(kc);
      n = (kc == 7'd0) ? 1 : ((kc > KEY_SLOTS) ? KEY_SLOTS : int'(kc));

      // well-formed table: non-decreasing times over every slot in use
      style  = $urandom_range(0, 2);
      narrow = 1'($urandom_range(0, 1));
      t_cur  = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom_range(0, 32'h8000_0000);
      span   = (32'hFFFF_FFFF - t_cur) / n;
      for (int s = 0; s < n; s++) begin
        if (s > 0) begin
          case (style)
            0: t_cur = t_cur + $urandom_range(0, 32'h0004_0000);
            1: t_cur = t_cur + $urandom_range(0, span);
            default: t_cur = t_cur + $urandom_range(0, 2);
          endcase
        end
        push_word(kvls_pkg::OP_WRITE, 6'(s), t_cur, key_value(narrow), key_value(narrow),
                  key_value(narrow), $urandom, 1'b0, '0);
        pace();
      end

      if (phase == 5) begin
        hold_off_req = 1'b1;
        for (int q = 0; q < 16; q++)
          push_word(kvls_pkg::OP_QUERY, 6'($urandom), $urandom, $urandom, $urandom,
                    $urandom, pick_sample_time(n), 1'b0, '0);
      end

      for (int q = 0; q < 40; q++) begin
        sel = $urandom_range(0, 99);
        if (sel < 8)
          push_word(kvls_pkg::OP_WRITE, 6'($urandom_range(0, KEY_SLOTS - 1)), $urandom,
                    $urandom, $urandom, $urandom, $urandom, 1'b0, '0);
        else if (sel < 18)
          push_word(kvls_pkg::OP_QUERY, 6'($urandom), $urandom, $urandom, $urandom,
                    $urandom, $urandom, 1'b0, '0);
        else
          push_word(kvls_pkg::OP_QUERY, 6'($urandom), $urandom, $urandom, $urandom,
                    $urandom, pick_sample_time(n), 1'b0, '0);
        pace();
        if ($urandom_range(0, 59) == 0) wait_results();
      end
      phase++;
    end

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** keyframe_vec3_lerp_sampler: PASSED **");
    end else begin
      $display("** keyframe_vec3_lerp_sampler: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("** keyframe_vec3_lerp_sampler: FAILED **");
    $finish;
  end

endmodule
